// File: sv/bdcs_pkg.sv
package bdcs_pkg;

    localparam int MAX_SIDE_DEF = 1024;
    localparam int LUMA_W       = 8;
    localparam int CFG_W        = 11;
    localparam int SEG_W        = 10;
    localparam int SUM_W        = 12;
    localparam int IDX_W        = 8;
    localparam int IN_TDATA_W   = 8;
    localparam int OUT_TDATA_W  = 24;

    localparam logic [CFG_W-1:0] SIDE_RESET = 11'd256;

    typedef struct packed {
        logic seg_start;   // first pixel of a block within a pixel row
        logic seg_end;     // last pixel of a block within a pixel row
        logic row_first;   // first pixel row of a block row
        logic row_last;    // last pixel row of a block row
        logic bc_nonzero;  // block column is not the leftmost
        logic img_last;    // last pixel of the image
    } t_raster_flags;

endpackage

// File: sv/bdcs_ram.sv
module bdcs_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/bdcs_raster.sv
module bdcs_raster
    import bdcs_pkg::*;
#(
    parameter int MAX_SIDE = MAX_SIDE_DEF,
    parameter int CW       = $clog2(MAX_SIDE),
    parameter int BCW      = CW - 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    output logic [BCW-1:0]   o_bc,
    output logic [BCW-1:0]   o_brow,
    output t_raster_flags    o_flags
);

    localparam int SW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;

    function automatic logic [CW:0] f_side(input logic [CFG_W-1:0] v);
        logic [SW-1:0] s;
        s = SW'({v[CFG_W-1:2], 2'b00});
        if (s < SW'(8)) begin
            s = SW'(8);
        end
        if (s > SW'(MAX_SIDE)) begin
            s = SW'(MAX_SIDE - (MAX_SIDE % 4));
        end
        return s[CW:0];
    endfunction

    logic [CW:0]   r_side;
    logic [CW-1:0] r_col, n_col;
    logic [CW-1:0] r_row, n_row;
    logic          col_last, row_last_px;

    assign col_last    = ({1'b0, r_col} == (r_side - (CW+1)'(1)));
    assign row_last_px = ({1'b0, r_row} == (r_side - (CW+1)'(1)));

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_adv) begin
            if (col_last) begin
                n_col = '0;
                n_row = row_last_px ? '0 : r_row + CW'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= f_side(SIDE_RESET);
            r_col  <= '0;
            r_row  <= '0;
        end else if (i_cfg_we) begin
            r_side <= f_side(i_cfg_wdata);
            r_col  <= '0;
            r_row  <= '0;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
        end
    end

    assign o_bc   = r_col[CW-1:2];
    assign o_brow = r_row[CW-1:2];

    assign o_flags.seg_start  = (r_col[1:0] == 2'd0);
    assign o_flags.seg_end    = (r_col[1:0] == 2'd3);
    assign o_flags.row_first  = (r_row[1:0] == 2'd0);
    assign o_flags.row_last   = (r_row[1:0] == 2'd3);
    assign o_flags.bc_nonzero = (r_col[CW-1:2] != '0);
    assign o_flags.img_last   = col_last && row_last_px;

`ifndef SYNTH
    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_col} < r_side))
        else $error("raster column beyond side");

    a_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_row} < r_side))
        else $error("raster row beyond side");

    a_wrap_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && !i_cfg_we && col_last && row_last_px) |=> (r_col == '0 && r_row == '0))
        else $error("raster did not wrap at end of image");
`endif

endmodule

// File: sv/bdcs_block_sum.sv
module bdcs_block_sum
    import bdcs_pkg::*;
#(
    parameter int MAX_SIDE = MAX_SIDE_DEF,
    parameter int BCW      = $clog2(MAX_SIDE) - 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  t_raster_flags     i_flags,
    input  logic [BCW-1:0]    i_bc,
    input  logic [LUMA_W-1:0] i_luma,
    output logic              o_bit
);

    logic [SEG_W-1:0] r_seg, n_seg;
    logic [SUM_W-1:0] r_prev;
    logic [SUM_W-1:0] ram_rd;
    logic [SUM_W-1:0] total;

    // running sum of the current block's pixels in this pixel row
    assign n_seg = i_flags.seg_start ? SEG_W'(i_luma) : r_seg + SEG_W'(i_luma);
    assign total = i_flags.row_first ? SUM_W'(n_seg) : ram_rd + SUM_W'(n_seg);
    assign o_bit = (r_prev > total);

    // column partial sum fetched at the block's first pixel, written back at its last
    bdcs_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_SIDE / 4),
        .AW    (BCW)
    ) u_col_sums (
        .i_clk   (i_clk),
        .i_we    (i_adv && i_flags.seg_end),
        .i_waddr (i_bc),
        .i_wdata (total),
        .i_re    (i_adv && i_flags.seg_start),
        .i_raddr (i_bc),
        .o_rdata (ram_rd)
    );

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_seg <= n_seg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
        end else if (i_adv && i_flags.seg_end && i_flags.row_last) begin
            r_prev <= total;
        end
    end

`ifndef SYNTH
    a_prev_tracks_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && i_flags.seg_end && i_flags.row_last) |=> (r_prev == $past(total)))
        else $error("previous block sum not updated");

    a_prev_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_adv && i_flags.seg_end && i_flags.row_last) |=> $stable(r_prev))
        else $error("previous block sum changed off block end");

    a_sum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && i_flags.seg_end && i_flags.row_first) |-> (total <= SUM_W'(1020)))
        else $error("single-row block sum out of range");
`endif

endmodule

// File: sv/block_dc_signature_unit.sv
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tdata[7:0] luma
// m_axis    out  m_axis_tvalid/m_axis_tready    tdata: bit, row, col; tlast: image done
// cfg       in   i_cfg_we                       i_cfg_wdata[10:0] image side
//
// One pixel per clock while s_axis_tready is high; a pixel is folded into its block sum in the cycle it is taken.
// A result reaches the output register in the cycle after the pixel that closes a block other than a leftmost one.
// The output register stalls input only when the next pixel closes a block other than a leftmost one.
// Reset and a side write restart the raster at pixel zero.
module block_dc_signature_unit
    import bdcs_pkg::*;
#(
    parameter int MAX_SIDE = MAX_SIDE_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] luma
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [0] signature_bit, [8:1] block_row,
                                                   // [16:9] block_col, [23:17] zero
    output logic                   m_axis_tlast,   // image_done
    input  logic                   i_cfg_we,
    input  logic [CFG_W-1:0]       i_cfg_wdata
);

    localparam int CW  = $clog2(MAX_SIDE);
    localparam int BCW = CW - 2;

    t_raster_flags    flags;
    logic [BCW-1:0]   bc, brow, bc_left;
    logic             adv, emit_pos, sig_bit;
    logic [BCW+7:0]   row_ext, col_ext;

    logic             r_out_valid;
    logic             r_bit;
    logic [IDX_W-1:0] r_row;
    logic [IDX_W-1:0] r_col;
    logic             r_done;

    assign emit_pos      = flags.seg_end && flags.row_last && flags.bc_nonzero;
    assign s_axis_tready = !r_out_valid || m_axis_tready || !emit_pos;
    assign adv           = s_axis_tvalid && s_axis_tready;

    bdcs_raster #(
        .MAX_SIDE (MAX_SIDE),
        .CW       (CW),
        .BCW      (BCW)
    ) u_raster (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_bc        (bc),
        .o_brow      (brow),
        .o_flags     (flags)
    );

    bdcs_block_sum #(
        .MAX_SIDE (MAX_SIDE),
        .BCW      (BCW)
    ) u_block_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_flags (flags),
        .i_bc    (bc),
        .i_luma  (s_axis_tdata[LUMA_W-1:0]),
        .o_bit   (sig_bit)
    );

    assign bc_left = bc - BCW'(1);
    assign row_ext = {8'b0, brow};
    assign col_ext = {8'b0, bc_left};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && emit_pos) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && emit_pos) begin
            r_bit  <= sig_bit;
            r_row  <= row_ext[IDX_W-1:0];
            r_col  <= col_ext[IDX_W-1:0];
            r_done <= flags.img_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0, r_col, r_row, r_bit};
    assign m_axis_tlast  = r_done;

`ifndef SYNTH
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && emit_pos) |-> (!r_out_valid || m_axis_tready))
        else $error("pending result overwritten");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && emit_pos) |=> m_axis_tvalid)
        else $error("closed block produced no result");

    a_done_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && emit_pos && flags.img_last) |-> flags.row_last)
        else $error("image end outside last block row");
`endif

endmodule
